>>> design/rfpwc_pkg.sv
// Shared types and constants of the pulse width capture block.
// Used by every module of the block; depends on nothing.
package rfpwc_pkg;

    localparam int STAMP_W    = 32;
    localparam int DUR_W      = 16;
    localparam int COUNT_W    = 12;
    localparam int CHAN_W     = 2;
    localparam int EN_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUR_W-1:0] MIN_START_RST  = 16'd2200;
    localparam logic [DUR_W-1:0] MAX_START_RST  = 16'd20000;
    localparam logic [DUR_W-1:0] MIN_PERIOD_RST = 16'd150;
    localparam logic [DUR_W-1:0] MAX_PERIOD_RST = 16'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_START   = 3'd0,
        CFG_MAX_START   = 3'd1,
        CFG_MIN_PERIOD  = 3'd2,
        CFG_MAX_PERIOD  = 3'd3,
        CFG_CHAN_ENABLE = 3'd4
    } t_cfg_index;

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef struct packed {
        logic [DUR_W-1:0] min_start_len;
        logic [DUR_W-1:0] max_start_len;
        logic [DUR_W-1:0] min_period_len;
        logic [DUR_W-1:0] max_period_len;
        logic [EN_W-1:0]  channel_enable;
    } t_cfg;

    // per-channel timing state, ring pointers are kept beside it
    typedef struct packed {
        logic [STAMP_W-1:0] last_stamp;
        logic               frame_active;
        logic               glitch_seen;
    } t_edge_state;

    // what the current word does to the ring
    typedef struct packed {
        logic pop_hit;
        logic push_one;
        logic push_two;
        logic first_marker;
        logic overflow;
    } t_plan;

endpackage

>>> design/rfpwc_state_mem.sv
// Per-channel state memory: one write port, one registered read port.
// Entries read as zero until first written; the last write is forwarded.
// Depends on rfpwc_pkg.
module rfpwc_state_mem #(
    parameter int CHANNELS = 3,
    parameter int WIDTH    = 50,
    localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [CW-1:0]    i_rd_addr,
    input  logic             i_wr_en,
    input  logic [CW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic [WIDTH-1:0] o_rd_data
);
    import rfpwc_pkg::*;

    logic [WIDTH-1:0] mem [CHANNELS];
    logic [CHANNELS-1:0] r_written;
    logic [WIDTH-1:0] r_rd_q;
    logic [CW-1:0]    r_rd_addr;
    logic             r_rd_init;
    logic             r_last_valid;
    logic [CW-1:0]    r_last_addr;
    logic [WIDTH-1:0] r_last_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q    <= mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
        if (i_wr_en) begin
            r_last_addr <= i_wr_addr;
            r_last_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_init    <= 1'b0;
            r_last_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
                r_last_valid         <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_init <= r_written[i_rd_addr];
            end
        end
    end

    // the latest write to an entry is its current content
    always_comb begin
        if (r_last_valid && (r_last_addr == r_rd_addr)) begin
            o_rd_data = r_last_data;
        end else if (!r_rd_init) begin
            o_rd_data = '0;
        end else begin
            o_rd_data = r_rd_q;
        end
    end

endmodule

>>> design/rfpwc_ring.sv
// Ring storage for all channels: one write port, one registered read port.
// Channel c owns LAST_INDEX+1 consecutive entries. Depends on rfpwc_pkg.
module rfpwc_ring #(
    parameter int LAST_INDEX = 255,
    parameter int CHANNELS   = 3,
    localparam int IW        = $clog2(LAST_INDEX + 1),
    localparam int CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [CW-1:0]               i_wr_chan,
    input  logic [IW-1:0]               i_wr_idx,
    input  logic [rfpwc_pkg::DUR_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [CW-1:0]               i_rd_chan,
    input  logic [IW-1:0]               i_rd_idx,
    output logic [rfpwc_pkg::DUR_W-1:0] o_rd_data
);
    import rfpwc_pkg::*;

    localparam int RING_LEN = LAST_INDEX + 1;
    localparam int DEPTH    = CHANNELS * RING_LEN;
    localparam int AW       = $clog2(DEPTH);

    logic [DUR_W-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    assign wr_addr = AW'(i_wr_chan) * AW'(RING_LEN) + AW'(i_wr_idx);
    assign rd_addr = AW'(i_rd_chan) * AW'(RING_LEN) + AW'(i_rd_idx);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/rfpwc_update.sv
// Edge classification and ring pointer update for one word.
// Pure logic between the state read and the write back. Depends on rfpwc_pkg.
module rfpwc_update #(
    parameter int LAST_INDEX = 255,
    parameter int CHANNELS   = 3,
    localparam int IW        = $clog2(LAST_INDEX + 1)
) (
    input  rfpwc_pkg::t_cfg                i_cfg,
    input  rfpwc_pkg::t_op                 i_op,
    input  logic [rfpwc_pkg::CHAN_W-1:0]   i_chan,
    input  logic [rfpwc_pkg::STAMP_W-1:0]  i_stamp,
    input  rfpwc_pkg::t_edge_state         i_st,
    input  logic [IW-1:0]                  i_widx,
    input  logic [IW-1:0]                  i_ridx,
    output rfpwc_pkg::t_edge_state         o_st,
    output logic [IW-1:0]                  o_widx,
    output logic [IW-1:0]                  o_ridx,
    output logic [IW-1:0]                  o_widx_second,
    output logic [rfpwc_pkg::DUR_W-1:0]    o_dur,
    output logic [rfpwc_pkg::COUNT_W-1:0]  o_count,
    output logic                           o_in_range,
    output rfpwc_pkg::t_plan               o_plan
);
    import rfpwc_pkg::*;

    localparam int PW = IW + 1;
    localparam logic [IW-1:0] LAST     = IW'(LAST_INDEX);
    localparam logic [PW-1:0] RING_LEN = PW'(LAST_INDEX + 1);

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
        return (idx == LAST) ? '0 : idx + 1'b1;
    endfunction

    logic [EN_W:0]    en_bits;
    logic             enabled;
    logic             wrap;
    logic [DUR_W-1:0] dur;
    logic [IW-1:0]    w1, r1, w2, r2;
    logic             ovf1, ovf2;
    logic [PW-1:0]    held;

    assign o_in_range = (32'(i_chan) < CHANNELS);
    assign en_bits    = {1'b0, i_cfg.channel_enable};
    assign enabled    = o_in_range && en_bits[i_chan];
    assign wrap       = i_stamp < i_st.last_stamp;
    assign dur        = i_stamp[DUR_W-1:0] - i_st.last_stamp[DUR_W-1:0];

    // pointers after one and after two pushes
    assign w1   = next_idx(i_widx);
    assign ovf1 = (w1 == i_ridx);
    assign r1   = ovf1 ? next_idx(i_ridx) : i_ridx;
    assign w2   = next_idx(w1);
    assign ovf2 = (w2 == r1);
    assign r2   = ovf2 ? next_idx(r1) : r1;

    assign o_widx_second = w1;
    assign o_dur         = dur;

    always_comb begin
        o_st   = i_st;
        o_widx = i_widx;
        o_ridx = i_ridx;
        o_plan = '0;
        if (!o_in_range) begin
            o_plan = '0;
        end else if (i_op == OP_POP) begin
            if (i_widx != i_ridx) begin
                o_plan.pop_hit = 1'b1;
                o_ridx         = next_idx(i_ridx);
            end
        end else if (enabled) begin
            if (wrap) begin
                o_st.last_stamp   = i_stamp;
                o_st.frame_active = 1'b0;
            end else if (dur < i_cfg.min_period_len) begin
                o_st.glitch_seen = 1'b1;
            end else if (i_st.glitch_seen) begin
                o_st.glitch_seen = 1'b0;
            end else if (i_st.frame_active && (dur > i_cfg.max_period_len)) begin
                // frame stop: marker only
                o_st.frame_active   = 1'b0;
                o_plan.push_one     = 1'b1;
                o_plan.first_marker = 1'b1;
                o_plan.overflow     = ovf1;
                o_widx              = w1;
                o_ridx              = r1;
            end else if (dur > i_cfg.max_start_len) begin
                o_st.frame_active = 1'b0;
            end else begin
                o_st.last_stamp = i_stamp;
                if ((dur > i_cfg.min_start_len) && (dur < i_cfg.max_start_len)
                        && !i_st.frame_active) begin
                    // frame start: marker then duration
                    o_st.frame_active   = 1'b1;
                    o_plan.push_two     = 1'b1;
                    o_plan.first_marker = 1'b1;
                    o_plan.overflow     = ovf1 | ovf2;
                    o_widx              = w2;
                    o_ridx              = r2;
                end else begin
                    o_plan.push_one = 1'b1;
                    o_plan.overflow = ovf1;
                    o_widx          = w1;
                    o_ridx          = r1;
                end
            end
        end
    end

    assign held    = (o_widx >= o_ridx) ? PW'(o_widx) - PW'(o_ridx)
                                        : RING_LEN + PW'(o_widx) - PW'(o_ridx);
    assign o_count = o_in_range ? COUNT_W'(held) : '0;

endmodule

>>> design/rf_pulse_width_capture.sv
// Pulse width capture for up to CHANNELS receivers, each with a ring of
// LAST_INDEX+1 durations. An edge that opens a frame stays in the update
// stage for an extra marker write, because its start marker and its
// duration share the single write port of the ring memory. A result is
// registered in the output register when its word leaves the update stage
// and waits there while the result side holds off. Channel state lives in
// a small memory read on acceptance and written back when the word leaves
// the update stage, with the last write forwarded. There is no clearing
// pass: ring entries are only read after being written.
// Depends on rfpwc_pkg, rfpwc_state_mem, rfpwc_ring and rfpwc_update.
module rf_pulse_width_capture #(
    parameter int LAST_INDEX = 255,
    parameter int CHANNELS   = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rfpwc_pkg::STAMP_W-1:0]     s_axis_tdata,  // [31:0] stamp
    input  logic [2:0]                        s_axis_tuser,  // [0] op, [2:1] chan
    // result words
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] data_value, [27:16] pending_count, [28] overflowed, [31:29] zero
    output logic [31:0]                       m_axis_tdata,
    output logic [0:0]                        m_axis_tuser,  // [0] data_valid
    // configuration
    input  logic                              i_cfg_we,
    input  logic [rfpwc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rfpwc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rfpwc_pkg::*;

    localparam int IW  = $clog2(LAST_INDEX + 1);
    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STW = $bits(t_edge_state);
    localparam int SW  = STW + 2 * IW;

    t_cfg r_cfg;

    // update stage
    logic               r_s1_valid;
    logic               r_s1_phase;
    t_op                r_s1_op;
    logic [CHAN_W-1:0]  r_s1_chan;
    logic [STAMP_W-1:0] r_s1_stamp;

    // output register
    logic               r_s2_valid;
    logic               r_s2_hit;
    logic [COUNT_W-1:0] r_s2_count;
    logic               r_s2_ovf;

    logic               accept;
    logic [CHAN_W-1:0]  in_chan;
    logic               in_range_in;
    logic [SW-1:0]      st_rd;
    logic [SW-1:0]      st_wr;
    t_edge_state        cur_st, nxt_st;
    logic [IW-1:0]      cur_w, cur_r, nxt_w, nxt_r, w_second;
    logic [DUR_W-1:0]   dur;
    logic [COUNT_W-1:0] count;
    logic               in_range;
    t_plan              plan;
    logic               first_write;
    logic               s1_done;
    logic               s1_adv;
    logic               ring_wr_en;
    logic [IW-1:0]      ring_wr_idx;
    logic [DUR_W-1:0]   ring_wr_data;
    logic               ring_rd_en;
    logic [DUR_W-1:0]   ring_q;
    logic [DUR_W-1:0]   out_value;

    assign in_chan     = s_axis_tuser[2:1];
    assign in_range_in = (32'(in_chan) < CHANNELS);
    assign accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_start_len  <= MIN_START_RST;
            r_cfg.max_start_len  <= MAX_START_RST;
            r_cfg.min_period_len <= MIN_PERIOD_RST;
            r_cfg.max_period_len <= MAX_PERIOD_RST;
            r_cfg.channel_enable <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MIN_START:   r_cfg.min_start_len  <= i_cfg_data;
                CFG_MAX_START:   r_cfg.max_start_len  <= i_cfg_data;
                CFG_MIN_PERIOD:  r_cfg.min_period_len <= i_cfg_data;
                CFG_MAX_PERIOD:  r_cfg.max_period_len <= i_cfg_data;
                CFG_CHAN_ENABLE: r_cfg.channel_enable <= i_cfg_data[EN_W-1:0];
                default: ;
            endcase
        end
    end

    rfpwc_state_mem #(
        .CHANNELS (CHANNELS),
        .WIDTH    (SW)
    ) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept && in_range_in),
        .i_rd_addr (CW'(in_chan)),
        .i_wr_en   (s1_adv && in_range),
        .i_wr_addr (CW'(r_s1_chan)),
        .i_wr_data (st_wr),
        .o_rd_data (st_rd)
    );

    assign cur_st = st_rd[SW-1 -: STW];
    assign cur_w  = st_rd[2*IW-1:IW];
    assign cur_r  = st_rd[IW-1:0];
    assign st_wr  = {nxt_st, nxt_w, nxt_r};

    rfpwc_update #(
        .LAST_INDEX (LAST_INDEX),
        .CHANNELS   (CHANNELS)
    ) u_update (
        .i_cfg         (r_cfg),
        .i_op          (r_s1_op),
        .i_chan        (r_s1_chan),
        .i_stamp       (r_s1_stamp),
        .i_st          (cur_st),
        .i_widx        (cur_w),
        .i_ridx        (cur_r),
        .o_st          (nxt_st),
        .o_widx        (nxt_w),
        .o_ridx        (nxt_r),
        .o_widx_second (w_second),
        .o_dur         (dur),
        .o_count       (count),
        .o_in_range    (in_range),
        .o_plan        (plan)
    );

    // a frame start writes its marker in a first phase, before its duration
    assign first_write   = r_s1_valid && plan.push_two && !r_s1_phase;
    assign s1_done       = r_s1_valid && !first_write;
    assign s1_adv        = s1_done && (!r_s2_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;

    assign ring_wr_en   = first_write || (s1_adv && (plan.push_one || plan.push_two));
    assign ring_wr_idx  = (plan.push_two && r_s1_phase) ? w_second : cur_w;
    assign ring_wr_data = (plan.first_marker && !r_s1_phase) ? '0 : dur;
    assign ring_rd_en   = s1_adv && plan.pop_hit;

    rfpwc_ring #(
        .LAST_INDEX (LAST_INDEX),
        .CHANNELS   (CHANNELS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ring_wr_en),
        .i_wr_chan (CW'(r_s1_chan)),
        .i_wr_idx  (ring_wr_idx),
        .i_wr_data (ring_wr_data),
        .i_rd_en   (ring_rd_en),
        .i_rd_chan (CW'(r_s1_chan)),
        .i_rd_idx  (cur_r),
        .o_rd_data (ring_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_phase <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s1_phase <= 1'b0;
            end else if (first_write) begin
                r_s1_phase <= 1'b1;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op    <= t_op'(s_axis_tuser[0]);
            r_s1_chan  <= in_chan;
            r_s1_stamp <= s_axis_tdata;
        end
        if (s1_adv) begin
            r_s2_hit   <= plan.pop_hit;
            r_s2_count <= count;
            r_s2_ovf   <= plan.overflow;
        end
    end

    assign out_value     = r_s2_hit ? ring_q : '0;
    assign m_axis_tvalid = r_s2_valid;
    assign m_axis_tdata  = {3'b000, r_s2_ovf, r_s2_count, out_value};
    assign m_axis_tuser  = r_s2_hit;

    a_phase_only_for_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_phase |-> (r_s1_valid && plan.push_two))
        else $error("second write phase without a frame start word");

    a_marker_then_duration: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        first_write |=> r_s1_phase)
        else $error("frame start did not move on to its duration write");

    a_pop_never_overflows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_hit) |-> !r_s2_ovf)
        else $error("popped word flagged as overflow");

    a_stall_blocks_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s2_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("word taken while update stage is held");

endmodule
